// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/isg_pkg.sv
package isg_pkg;

    localparam int NUM_COVARIATES = 4;
    localparam int TIME_BITS      = 24;
    localparam int COV_BITS       = 16;
    localparam int DUR_BITS       = 40;
    localparam int WSUM_BITS      = 56;
    localparam int PROD_BITS      = TIME_BITS + 1 + COV_BITS;
    localparam int COV_IDX_BITS   = (NUM_COVARIATES > 1) ? $clog2(NUM_COVARIATES) : 1;
    localparam int QUOT_BITS      = 17;
    localparam int STEP_BITS      = $clog2(QUOT_BITS);
    localparam int PADDR_BITS     = 3;

    localparam logic [PADDR_BITS-1:0] ADDR_AVERAGE_MODE = 3'd0;

    typedef struct packed {
        logic [TIME_BITS-1:0]       start_time;
        logic [TIME_BITS-1:0]       stop_time;
        logic                       event_status;
        logic signed [COV_BITS-1:0] cov_0;
        logic signed [COV_BITS-1:0] cov_1;
        logic signed [COV_BITS-1:0] cov_2;
        logic signed [COV_BITS-1:0] cov_3;
        logic                       last_row;
    } t_row;

    typedef struct packed {
        logic                       subject_status;
        logic [15:0]                row_count;
        logic [15:0]                subject_number;
        logic signed [COV_BITS-1:0] mean_0;
        logic signed [COV_BITS-1:0] mean_1;
        logic signed [COV_BITS-1:0] mean_2;
        logic signed [COV_BITS-1:0] mean_3;
        logic                       zero_duration;
        logic                       final_subject;
    } t_summary;

    typedef struct packed {
        logic                                          status;
        logic [15:0]                                   rows;
        logic [15:0]                                   subj;
        logic [DUR_BITS-1:0]                           dsum;
        logic [NUM_COVARIATES-1:0][WSUM_BITS-1:0]      wsum;
        logic [NUM_COVARIATES-1:0][COV_BITS-1:0]       lcov;
        logic                                          mode;
        logic                                          final_flag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CHECK,
        F_ACC,
        F_FLUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

// File: rtl/isg_queue.sv
module isg_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  isg_pkg::t_job       i_job,
    input  logic                i_pop,
    output isg_pkg::t_job       o_job,
    output isg_pkg::t_q_status  o_status
);

    isg_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_job          = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

endmodule

// File: rtl/isg_front.sv
module isg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  isg_pkg::t_row       i_row,
    input  logic                i_mode,
    input  isg_pkg::t_q_status  i_q,
    output logic                o_push,
    output isg_pkg::t_job       o_job
);

    localparam int NC = isg_pkg::NUM_COVARIATES;
    localparam int TB = isg_pkg::TIME_BITS;
    localparam int DB = isg_pkg::DUR_BITS;
    localparam int WB = isg_pkg::WSUM_BITS;
    localparam int PB = isg_pkg::PROD_BITS;
    localparam int CB = isg_pkg::COV_BITS;

    isg_pkg::t_front_state r_state, n_state;
    isg_pkg::t_row         r_in, n_in;
    logic [TB-1:0]         r_prev_stop, n_prev_stop;
    logic                  r_prev_status, n_prev_status;
    logic [NC-1:0][CB-1:0] r_lcov, n_lcov;
    logic [15:0]           r_rows, n_rows;
    logic [15:0]           r_subj, n_subj;
    logic                  r_first, n_first;
    logic [DB-1:0]         r_dsum, n_dsum;
    logic [NC-1:0][WB-1:0] r_wsum, n_wsum;

    logic signed [TB:0]    dur;
    logic signed [CB-1:0]  cov    [NC];
    logic signed [PB-1:0]  prod   [NC];
    logic signed [WB:0]    wsum_s [NC];
    logic signed [DB:0]    dsum_s;
    logic                  close;

    assign dur    = $signed({1'b0, r_in.stop_time}) - $signed({1'b0, r_in.start_time});
    assign cov[0] = r_in.cov_0;
    assign cov[1] = r_in.cov_1;
    assign cov[2] = r_in.cov_2;
    assign cov[3] = r_in.cov_3;
    assign dsum_s = (DB+1)'($signed(r_dsum)) + (DB+1)'(dur);
    assign close  = !r_first && (r_in.start_time < r_prev_stop);

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            prod[k]   = PB'(dur * cov[k]);
            wsum_s[k] = (WB+1)'($signed(r_wsum[k])) + (WB+1)'(prod[k]);
        end
    end

    // snapshot of the open subject
    always_comb begin
        o_job.status     = r_prev_status;
        o_job.rows       = r_rows;
        o_job.subj       = r_subj;
        o_job.dsum       = r_dsum;
        o_job.wsum       = r_wsum;
        o_job.lcov       = r_lcov;
        o_job.mode       = i_mode;
        o_job.final_flag = (r_state == isg_pkg::F_FLUSH);
    end

    assign o_stall = (r_state != isg_pkg::F_IDLE);

    always_comb begin
        n_state       = r_state;
        n_in          = r_in;
        n_prev_stop   = r_prev_stop;
        n_prev_status = r_prev_status;
        n_lcov        = r_lcov;
        n_rows        = r_rows;
        n_subj        = r_subj;
        n_first       = r_first;
        n_dsum        = r_dsum;
        n_wsum        = r_wsum;
        o_push        = 1'b0;
        case (r_state)
            isg_pkg::F_IDLE: begin
                if (i_valid) begin
                    n_in    = i_row;
                    n_state = isg_pkg::F_CHECK;
                end
            end
            isg_pkg::F_CHECK: begin
                if (!close) begin
                    n_state = isg_pkg::F_ACC;
                end else if (!i_q.full) begin
                    o_push  = 1'b1;
                    n_rows  = '0;
                    n_dsum  = '0;
                    n_wsum  = '0;
                    if (r_subj != 16'hFFFF) n_subj = r_subj + 16'd1;
                    n_state = isg_pkg::F_ACC;
                end
            end
            isg_pkg::F_ACC: begin
                n_first       = 1'b0;
                if (r_rows != 16'hFFFF) n_rows = r_rows + 16'd1;
                if (dsum_s[DB] != dsum_s[DB-1]) begin
                    n_dsum = dsum_s[DB] ? {1'b1, {(DB-1){1'b0}}} : {1'b0, {(DB-1){1'b1}}};
                end else begin
                    n_dsum = dsum_s[DB-1:0];
                end
                for (int k = 0; k < NC; k++) begin
                    n_lcov[k] = cov[k];
                    if (wsum_s[k][WB] != wsum_s[k][WB-1]) begin
                        n_wsum[k] = wsum_s[k][WB] ? {1'b1, {(WB-1){1'b0}}}
                                                  : {1'b0, {(WB-1){1'b1}}};
                    end else begin
                        n_wsum[k] = wsum_s[k][WB-1:0];
                    end
                end
                n_prev_stop   = r_in.stop_time;
                n_prev_status = r_in.event_status;
                n_state       = r_in.last_row ? isg_pkg::F_FLUSH : isg_pkg::F_IDLE;
            end
            isg_pkg::F_FLUSH: begin
                if (!i_q.full) begin
                    o_push  = 1'b1;
                    n_rows  = '0;
                    n_dsum  = '0;
                    n_wsum  = '0;
                    n_subj  = '0;
                    n_first = 1'b1;
                    n_state = isg_pkg::F_IDLE;
                end
            end
            default: n_state = isg_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= isg_pkg::F_IDLE;
            r_prev_stop   <= '0;
            r_prev_status <= 1'b0;
            r_lcov        <= '0;
            r_rows        <= '0;
            r_subj        <= '0;
            r_first       <= 1'b1;
            r_dsum        <= '0;
            r_wsum        <= '0;
        end else begin
            r_state       <= n_state;
            r_prev_stop   <= n_prev_stop;
            r_prev_status <= n_prev_status;
            r_lcov        <= n_lcov;
            r_rows        <= n_rows;
            r_subj        <= n_subj;
            r_first       <= n_first;
            r_dsum        <= n_dsum;
            r_wsum        <= n_wsum;
        end
    end

endmodule

// File: rtl/isg_back.sv
module isg_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  isg_pkg::t_job       i_job,
    input  isg_pkg::t_q_status  i_q,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output isg_pkg::t_summary   o_summary
);

    localparam int NC = isg_pkg::NUM_COVARIATES;
    localparam int DB = isg_pkg::DUR_BITS;
    localparam int WB = isg_pkg::WSUM_BITS;
    localparam int CB = isg_pkg::COV_BITS;
    localparam int QB = isg_pkg::QUOT_BITS;
    localparam int SB = isg_pkg::STEP_BITS;
    localparam int KB = isg_pkg::COV_IDX_BITS;

    isg_pkg::t_back_state  r_state, n_state;
    isg_pkg::t_job         r_job, n_job;
    logic [NC-1:0][CB-1:0] r_mean, n_mean;
    logic [KB-1:0]         r_k, n_k;
    logic [SB-1:0]         r_step, n_step;
    logic [WB-1:0]         r_rem, n_rem;
    logic [WB-1:0]         r_dsh, n_dsh;
    logic [QB-1:0]         r_q, n_q;
    logic                  r_neg, n_neg;
    logic                  r_sat, n_sat;
    logic                  r_ovalid, n_ovalid;
    isg_pkg::t_summary     r_osum, n_osum;

    logic                  zd;
    logic [WB-1:0]         num;
    logic [WB-1:0]         nmag;
    logic [DB-1:0]         dmag;
    logic                  ge;
    logic [QB-1:0]         q_nx;

    function automatic logic [CB-1:0] fin(input logic sat, input logic neg,
                                          input logic [QB-1:0] q);
        logic [QB-1:0] qn;
        qn = -q;
        if (neg) begin
            fin = (sat || q > QB'(32768)) ? 16'h8000 : qn[CB-1:0];
        end else begin
            fin = (sat || q > QB'(32767)) ? 16'h7FFF : q[CB-1:0];
        end
    endfunction

    assign zd   = r_job.mode && (r_job.dsum == '0);
    assign num  = r_job.wsum[r_k];
    assign nmag = num[WB-1] ? -num : num;
    assign dmag = r_job.dsum[DB-1] ? -r_job.dsum : r_job.dsum;
    assign ge   = (r_rem >= r_dsh);
    assign q_nx = ge ? (r_q | (QB'(1) << r_step)) : r_q;

    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_mean   = r_mean;
        n_k      = r_k;
        n_step   = r_step;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_q      = r_q;
        n_neg    = r_neg;
        n_sat    = r_sat;
        n_osum   = r_osum;
        n_ovalid = r_ovalid && i_stall;
        o_pop    = 1'b0;
        case (r_state)
            isg_pkg::B_IDLE: begin
                if (!i_q.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_k     = '0;
                    n_state = isg_pkg::B_LOAD;
                end
            end
            isg_pkg::B_LOAD: begin
                if (!r_job.mode) begin
                    n_mean  = r_job.lcov;
                    n_state = isg_pkg::B_OUT;
                end else if (zd) begin
                    n_mean  = '0;
                    n_state = isg_pkg::B_OUT;
                end else begin
                    n_rem   = nmag;
                    n_dsh   = {dmag, {(QB-1){1'b0}}};
                    n_q     = '0;
                    n_step  = SB'(QB - 1);
                    n_neg   = num[WB-1] ^ r_job.dsum[DB-1];
                    n_sat   = {1'b0, nmag} >= {dmag, {QB{1'b0}}};
                    n_state = isg_pkg::B_DIV;
                end
            end
            isg_pkg::B_DIV: begin
                if (ge) n_rem = r_rem - r_dsh;
                n_dsh = r_dsh >> 1;
                n_q   = q_nx;
                n_step = r_step - SB'(1);
                if (r_step == '0) begin
                    n_mean[r_k] = fin(r_sat, r_neg, q_nx);
                    if (r_k == KB'(NC - 1)) begin
                        n_state = isg_pkg::B_OUT;
                    end else begin
                        n_k     = r_k + KB'(1);
                        n_state = isg_pkg::B_LOAD;
                    end
                end
            end
            isg_pkg::B_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid                = 1'b1;
                    n_osum.subject_status   = r_job.status;
                    n_osum.row_count        = r_job.rows;
                    n_osum.subject_number   = r_job.subj;
                    n_osum.mean_0           = r_mean[0];
                    n_osum.mean_1           = r_mean[1];
                    n_osum.mean_2           = r_mean[2];
                    n_osum.mean_3           = r_mean[3];
                    n_osum.zero_duration    = zd;
                    n_osum.final_subject    = r_job.final_flag;
                    n_state                 = isg_pkg::B_IDLE;
                end
            end
            default: n_state = isg_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job  <= n_job;
        r_mean <= n_mean;
        r_k    <= n_k;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_dsh  <= n_dsh;
        r_q    <= n_q;
        r_neg  <= n_neg;
        r_sat  <= n_sat;
        r_osum <= n_osum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= isg_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_valid   = r_ovalid;
    assign o_summary = r_osum;

endmodule

// File: rtl/interval_subject_grouper_top.sv
// Interval subject grouper.
// Input channel: one beat per interval row on i_row, taken when i_valid is
// high and o_stall is low. Output channel: one beat per subject summary on
// o_summary, taken when o_valid is high and i_stall is low.
// A row passes the front through capture, close check and accumulate, plus a
// flush if last_row is set; o_stall is high in all states but capture. A close
// check that ends a subject, and the flush, also wait while the two-entry job
// queue is full. A closed subject passes the back through pop, load and output
// in last mode or with a zero duration sum; in mean mode the shared restoring
// divider adds, per covariate, a load step and 17 quotient bits.
// Configuration: APB register average_mode at byte address 0, reset value 1;
// write only while the block is idle. pready is tied high.
// Reset (synchronous, active low) clears the sums, row and subject counts, the
// queue and output valid, and marks the next row as the first of a data set.
// When the receiver stalls, the summary holds in the output register, the
// back holds its next result, the queue fills, and then the front stalls rows.
module interval_subject_grouper_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  isg_pkg::t_row                        i_row,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output isg_pkg::t_summary                    o_summary,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [isg_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic               r_mode;
    logic               push;
    logic               pop;
    isg_pkg::t_job      job_in;
    isg_pkg::t_job      job_out;
    isg_pkg::t_q_status q_status;

    // config write completes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (psel && penable && pwrite && paddr == isg_pkg::ADDR_AVERAGE_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == isg_pkg::ADDR_AVERAGE_MODE) ? {31'b0, r_mode} : 32'b0;

    // front: classify rows, accumulate sums, hand closed subjects to the queue
    isg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_row   (i_row),
        .i_mode  (r_mode),
        .i_q     (q_status),
        .o_push  (push),
        .o_job   (job_in)
    );

    // queue: decouple row intake from the divider
    isg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job_in),
        .i_pop    (pop),
        .o_job    (job_out),
        .o_status (q_status)
    );

    // back: divide sums into means (or pass the last covariates) and drive the output register
    isg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (job_out),
        .i_q       (q_status),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_summary (o_summary)
    );

endmodule

// File: rtl/isg_checker.sv
`include "assert_macros.svh"

module isg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input isg_pkg::t_summary               o_summary,
    input logic                            pready
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_summary))
    `ASSERT_IMPL(a_rows_nonzero, i_clk, i_rst_n, o_valid, o_summary.row_count != 16'd0)
    `ASSERT_IMPL(a_zd_means, i_clk, i_rst_n, o_valid && o_summary.zero_duration, (o_summary.mean_0 == 16'sd0) && (o_summary.mean_1 == 16'sd0) && (o_summary.mean_2 == 16'sd0) && (o_summary.mean_3 == 16'sd0))
    `ASSERT_IMPL(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind interval_subject_grouper_top isg_checker u_isg_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_summary (o_summary),
    .pready    (pready)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

class summary_scoreboard;
    isg_pkg::t_summary pending[$];
    int unsigned       errors;

    // Predictor state
    bit                  avg_mode;
    logic [23:0]         prev_stop;
    bit                  prev_status;
    longint              last_cov[4];
    int unsigned         rows;
    int unsigned         subj;
    bit                  first_pending;
    longint              dur_sum;
    longint              wsum[4];

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        avg_mode = 1'b1;
        prev_stop = '0;
        prev_status = 1'b0;
        foreach (last_cov[k]) last_cov[k] = 0;
        subj = 0;
        first_pending = 1'b1;
        clear_subject();
    endfunction

    function void clear_subject();
        rows = 0;
        dur_sum = 0;
        foreach (wsum[k]) wsum[k] = 0;
    endfunction

    function longint clamp(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function void push_summary(bit is_final);
        isg_pkg::t_summary s;
        bit                zd;
        longint            m[4];
        zd = avg_mode && (dur_sum == 0);
        for (int k = 0; k < 4; k++) begin
            if (!avg_mode) m[k] = last_cov[k];
            else if (zd) m[k] = 0;
            else m[k] = clamp(wsum[k] / dur_sum, 16);
        end
        s.subject_status = prev_status;
        s.row_count = rows[15:0];
        s.subject_number = subj[15:0];
        s.mean_0 = m[0][15:0];
        s.mean_1 = m[1][15:0];
        s.mean_2 = m[2][15:0];
        s.mean_3 = m[3][15:0];
        s.zero_duration = zd;
        s.final_subject = is_final;
        pending.push_back(s);
    endfunction

    function void note_row(isg_pkg::t_row r);
        longint dur;
        longint c[4];
        dur = longint'(r.stop_time) - longint'(r.start_time);
        c[0] = r.cov_0; c[1] = r.cov_1; c[2] = r.cov_2; c[3] = r.cov_3;
        if (!first_pending && r.start_time < prev_stop) begin
            push_summary(1'b0);
            if (subj < 16'hFFFF) subj++;
            clear_subject();
        end
        first_pending = 1'b0;
        if (rows < 16'hFFFF) rows++;
        dur_sum = clamp(dur_sum + dur, 40);
        for (int k = 0; k < 4; k++) begin
            last_cov[k] = c[k];
            wsum[k] = clamp(wsum[k] + dur * c[k], 56);
        end
        prev_stop = r.stop_time;
        prev_status = r.event_status;
        if (r.last_row) begin
            push_summary(1'b1);
            clear_subject();
            subj = 0;
            first_pending = 1'b1;
        end
    endfunction

    function void check_summary(isg_pkg::t_summary got);
        isg_pkg::t_summary want;
        if (pending.size() == 0) begin
            $display("%0t: unexpected summary %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.subject_status !== want.subject_status)
            $display("%0t: subject_status exp %0d got %0d", $time,
                     want.subject_status, got.subject_status);
        if (got.row_count !== want.row_count)
            $display("%0t: row_count exp %0d got %0d", $time, want.row_count, got.row_count);
        if (got.subject_number !== want.subject_number)
            $display("%0t: subject_number exp %0d got %0d", $time,
                     want.subject_number, got.subject_number);
        if (got.mean_0 !== want.mean_0)
            $display("%0t: mean_0 exp %0d got %0d", $time, want.mean_0, got.mean_0);
        if (got.mean_1 !== want.mean_1)
            $display("%0t: mean_1 exp %0d got %0d", $time, want.mean_1, got.mean_1);
        if (got.mean_2 !== want.mean_2)
            $display("%0t: mean_2 exp %0d got %0d", $time, want.mean_2, got.mean_2);
        if (got.mean_3 !== want.mean_3)
            $display("%0t: mean_3 exp %0d got %0d", $time, want.mean_3, got.mean_3);
        if (got.zero_duration !== want.zero_duration)
            $display("%0t: zero_duration exp %0d got %0d", $time,
                     want.zero_duration, got.zero_duration);
        if (got.final_subject !== want.final_subject)
            $display("%0t: final_subject exp %0d got %0d", $time,
                     want.final_subject, got.final_subject);
        if (got !== want) errors++;
    endfunction
endclass

module testbench;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    isg_pkg::t_row                  i_row = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    isg_pkg::t_summary              o_summary;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [isg_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    summary_scoreboard board = new();
    bit          stall_quiet = 1'b0;
    logic [23:0] clock_now = '0;   // running stop time used to build subjects

    interval_subject_grouper_top u_top (.*);

    always #1 i_clk = ~i_clk;

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output side: random stall, check every beat taken.
    always @(negedge i_clk) begin
        if (stall_quiet) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_summary(o_summary);
    end

    task automatic write_mode(bit value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= isg_pkg::ADDR_AVERAGE_MODE;
        pwdata <= {31'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        board.avg_mode = value;
    endtask

    // Drop valid, hold until every expected summary is in, then let the back drain.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    // Send one beat; hold payload and valid until it is taken. Valid drops
    // only when a gap follows, so a beat sent right after keeps one update.
    task automatic send_row(isg_pkg::t_row r);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_row <= r;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_row(r);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_cov();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Build a row that continues (or, with new_subj, restarts) the timeline.
    function automatic isg_pkg::t_row make_row(bit new_subj, bit last);
        isg_pkg::t_row r;
        int            d;
        if (new_subj && clock_now != 0) r.start_time = clock_now - 24'($urandom_range(1, 1000));
        else if ($urandom_range(0, 1)) r.start_time = clock_now;
        else r.start_time = clock_now + 24'($urandom_range(0, 50));
        if (r.start_time > clock_now && new_subj) r.start_time = 0;
        case ($urandom_range(0, 9))
            0: d = 0;
            1: d = -int'($urandom_range(1, 100));
            2: d = $urandom_range(100000, 4000000);
            default: d = $urandom_range(1, 200);
        endcase
        r.stop_time = r.start_time + 24'(d);
        r.event_status = $urandom_range(0, 1);
        r.cov_0 = rand_cov(); r.cov_1 = rand_cov();
        r.cov_2 = rand_cov(); r.cov_3 = rand_cov();
        r.last_row = last;
        clock_now = r.stop_time;
        return r;
    endfunction

    function automatic isg_pkg::t_row fixed_row(logic [23:0] st, logic [23:0] sp, bit ev,
                                                logic [15:0] c, bit last);
        isg_pkg::t_row r;
        r.start_time = st; r.stop_time = sp; r.event_status = ev;
        r.cov_0 = c; r.cov_1 = ~c; r.cov_2 = c ^ 16'h5A5A; r.cov_3 = -c;
        r.last_row = last;
        clock_now = sp;
        return r;
    endfunction

    task automatic random_phase(int n_rows);
        int left;
        int len;
        left = n_rows;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            for (int i = 0; i < len && left > 0; i++) begin
                // Rarely feed noise: wholly random fields.
                if ($urandom_range(0, 15) == 0)
                    send_row(isg_pkg::t_row'({$urandom, $urandom, $urandom, $urandom}));
                else send_row(make_row(i == 0, (left == 1) || $urandom_range(0, 40) == 0));
                left--;
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of times and covariates, equal times, negative
        // and zero durations, then flush.
        send_row(fixed_row(24'd0, 24'd0, 1'b1, 16'h7FFF, 1'b0));
        send_row(fixed_row(24'd0, 24'd10, 1'b0, 16'h8000, 1'b0));
        send_row(fixed_row(24'd5, 24'd5, 1'b1, 16'h0001, 1'b0));
        send_row(fixed_row(24'd5, 24'd2, 1'b0, 16'hFFFF, 1'b0));
        send_row(fixed_row(24'd1, 24'hFFFFFF, 1'b1, 16'h7FFF, 1'b0));
        send_row(fixed_row(24'd0, 24'hFFFFFF, 1'b0, 16'h7FFF, 1'b0));
        send_row(fixed_row(24'hFFFFFF, 24'd0, 1'b1, 16'h8000, 1'b0));
        send_row(fixed_row(24'd0, 24'd1, 1'b0, 16'h8000, 1'b0));
        send_row(fixed_row(24'd0, 24'd3, 1'b1, 16'h0100, 1'b1));
        send_row(fixed_row(24'd100, 24'd100, 1'b1, 16'h1234, 1'b1));
        send_row(fixed_row(24'd9, 24'd7, 1'b0, 16'h4321, 1'b0));
        send_row(fixed_row(24'd7, 24'd9, 1'b1, 16'h0F0F, 1'b0));
        send_row(fixed_row(24'd3, 24'd4, 1'b0, 16'hF0F0, 1'b1));
        wait_drained();

        write_mode(1'b0);
        send_row(fixed_row(24'd0, 24'd8, 1'b1, 16'h8000, 1'b0));
        send_row(fixed_row(24'd2, 24'd2, 1'b0, 16'h7FFF, 1'b0));
        send_row(fixed_row(24'd2, 24'd2, 1'b1, 16'h0000, 1'b1));
        random_phase(150);
        wait_drained();

        write_mode(1'b1);
        random_phase(200);
        // Pause the sender until everything has come out.
        wait_drained();
        random_phase(80);
        wait_drained();

        write_mode(1'b0);
        random_phase(80);
        wait_drained();
        write_mode(1'b1);
        stall_quiet = 1'b1;   // stretch with no receiver stalls
        random_phase(80);
        wait_drained();
        stall_quiet = 1'b0;

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
